### rtl/touch_gesture_dimmer_top_macros.svh
// Assertion macros shared by the touch gesture dimmer RTL.
`ifndef TOUCH_GESTURE_DIMMER_TOP_MACROS_SVH
`define TOUCH_GESTURE_DIMMER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define TGD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("touch gesture dimmer: invariant violated");
`else
`define TGD_ASSERT_ALWAYS(lbl, cond)
`endif

`ifndef SYNTHESIS
`define TGD_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("touch gesture dimmer: implication violated");
`else
`define TGD_ASSERT_IMPLIES(lbl, ante, cons)
`endif

`endif

### rtl/tgd_pkg.sv
// Types and constants of the touch gesture dimmer.
package tgd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIN_INVERT      = 3'd0,
    REG_SETTLE_TICKS    = 3'd1,
    REG_HOLD_THRESH_MS  = 3'd2,
    REG_DTAP_WINDOW_MS  = 3'd3,
    REG_BRIGHT_STEP     = 3'd4,
    REG_BRIGHT_STEP_MS  = 3'd5,
    REG_CT_STEP         = 3'd6,
    REG_CT_STEP_MS      = 3'd7
  } reg_idx_t;

  localparam logic [15:0] RST_SETTLE_TICKS   = 16'd40;
  localparam logic [15:0] RST_HOLD_THRESH_MS = 16'd450;
  localparam logic [15:0] RST_DTAP_WINDOW_MS = 16'd300;
  localparam logic [7:0]  RST_BRIGHT_STEP    = 8'd2;
  localparam logic [15:0] RST_BRIGHT_STEP_MS = 16'd20;
  localparam logic [8:0]  RST_CT_STEP        = 9'd5;
  localparam logic [15:0] RST_CT_STEP_MS     = 16'd40;
  localparam logic [7:0]  LEVEL_RESET        = 8'd128;
  localparam logic [15:0] AGE_MAX            = 16'hFFFF;

  typedef struct packed {
    logic        pin_invert;
    logic [15:0] settle_ticks;
    logic [15:0] hold_after;
    logic [15:0] dtap_window;
    logic [7:0]  level_step;
    logic [15:0] level_interval;
    logic [8:0]  ct_step;
    logic [15:0] ct_interval;
  } cfg_t;

  typedef struct packed {
    logic pin_level;
    logic consume_tap;
  } sample_t;

  // Classified tick as it travels from front to back.
  typedef struct packed {
    logic touched;
    logic consume_tap;
  } tick_t;

  typedef struct packed {
    logic       press_pulse;
    logic       power_toggle;
    logic       hold_mode;
    logic       mode_flip;
    logic [7:0] brightness_level;
    logic       brightness_update;
    logic [8:0] ct_mired;
    logic       ct_update;
    logic       level_commit;
    logic       commit_ct;
  } result_t;

endpackage

### rtl/tgd_front.sv
// Front end: accept ticks, classify the pin level, buffer in a two-entry queue.
`include "touch_gesture_dimmer_top_macros.svh"

module tgd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             pin_invert,
  input  logic             push,
  output logic             full,
  input  tgd_pkg::sample_t sample,
  output logic             head_valid,
  output tgd_pkg::tick_t   head,
  input  logic             take
);

  tgd_pkg::tick_t slot [2];
  logic           rd_ptr;
  logic           wr_ptr;
  logic [1:0]     count;
  logic [1:0]     count_next;
  logic           do_push;
  logic           do_take;
  tgd_pkg::tick_t classified;

  assign full       = count[1];
  assign head_valid = (count != 2'd0);
  assign head       = slot[rd_ptr];
  assign do_push    = push & ~full;
  assign do_take    = take & head_valid;

  always_comb begin
    classified.touched     = sample.pin_level ^ pin_invert;
    classified.consume_tap = sample.consume_tap;
  end

  always_comb begin
    count_next = count;
    if (do_push && !do_take) begin
      count_next = count + 2'd1;
    end else if (!do_push && do_take) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_take) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= classified;
    end
  end

  `TGD_ASSERT_ALWAYS(a_front_count_bound, count != 2'd3)

endmodule

### rtl/tgd_core.sv
// Back: debounce, press tracking, hold ramp, tap timing; one tick per ready cycle.
`include "touch_gesture_dimmer_top_macros.svh"

module tgd_core #(
  parameter int BRIGHT_MIN = 0,
  parameter int BRIGHT_MAX = 255,
  parameter int TEMP_MIN   = 200,
  parameter int TEMP_MAX   = 455
) (
  input  logic             clk,
  input  logic             rst,
  input  tgd_pkg::cfg_t    cfg,
  input  logic             tick_valid,
  input  tgd_pkg::tick_t   tick,
  input  logic             out_ready,
  output logic             tick_take,
  output tgd_pkg::result_t res
);

  localparam logic signed [10:0] B_LO = 11'(BRIGHT_MIN);
  localparam logic signed [10:0] B_HI = 11'(BRIGHT_MAX);
  localparam logic signed [10:0] T_LO = 11'(TEMP_MIN);
  localparam logic signed [10:0] T_HI = 11'(TEMP_MAX);
  localparam logic [8:0] TEMP_RESET   = 9'((TEMP_MIN + TEMP_MAX) / 2);

  typedef struct packed {
    logic [8:0] value;
    logic       down;
  } ramp_t;

  function automatic logic [15:0] age_inc(input logic [15:0] a);
    age_inc = (a == tgd_pkg::AGE_MAX) ? a : a + 16'd1;
  endfunction

  // Step, clamp, and turn around at either end.
  function automatic ramp_t ramp_step(input logic [8:0] cur, input logic [8:0] step,
                                      input logic down, input logic signed [10:0] lo,
                                      input logic signed [10:0] hi);
    logic signed [10:0] v;
    ramp_t              r;
    if (down) begin
      v = $signed({2'b00, cur}) - $signed({2'b00, step});
    end else begin
      v = $signed({2'b00, cur}) + $signed({2'b00, step});
    end
    if (v < lo) begin
      v = lo;
    end
    if (v > hi) begin
      v = hi;
    end
    r.value = v[8:0];
    r.down  = down;
    if (v == hi && !down) begin
      r.down = 1'b1;
    end else if (v == lo && down) begin
      r.down = 1'b0;
    end
    ramp_step = r;
  endfunction

  logic        stable_touched, stable_touched_next;
  logic [15:0] debounce_left, debounce_left_next;
  logic        debounce_busy, debounce_busy_next;
  logic        is_pressed, is_pressed_next;
  logic [15:0] press_age, press_age_next;
  logic        hold_on, hold_on_next;
  logic [15:0] step_age, step_age_next;
  logic        ramp_down, ramp_down_next;
  logic        next_ramp_down, next_ramp_down_next;
  logic        tap_pending, tap_pending_next;
  logic [15:0] tap_age, tap_age_next;
  logic        suppress_tap, suppress_tap_next;
  logic        mode_ct, mode_ct_next;
  logic [7:0]  level_now, level_now_next;
  logic [8:0]  temp_now, temp_now_next;
  ramp_t       rb;
  ramp_t       rc;

  assign tick_take = tick_valid & out_ready;

  always_comb begin
    stable_touched_next = stable_touched;
    debounce_left_next  = debounce_left;
    debounce_busy_next  = debounce_busy;
    is_pressed_next     = is_pressed;
    hold_on_next        = hold_on;
    ramp_down_next      = ramp_down;
    next_ramp_down_next = next_ramp_down;
    tap_pending_next    = tap_pending;
    suppress_tap_next   = suppress_tap;
    mode_ct_next        = mode_ct;
    level_now_next      = level_now;
    temp_now_next       = temp_now;
    press_age_next      = age_inc(press_age);
    step_age_next       = age_inc(step_age);
    tap_age_next        = age_inc(tap_age);
    res                 = '0;

    // Debounce, then press or release on the resample.
    if (debounce_busy) begin
      if (debounce_left <= 16'd1) begin
        debounce_busy_next = 1'b0;
        debounce_left_next = 16'd0;
        if (tick.touched != stable_touched) begin
          stable_touched_next = tick.touched;
          if (tick.touched) begin
            is_pressed_next   = 1'b1;
            press_age_next    = 16'd0;
            hold_on_next      = 1'b0;
            suppress_tap_next = 1'b0;
            res.press_pulse   = 1'b1;
            if (tick.consume_tap) begin
              suppress_tap_next = 1'b1;
              tap_pending_next  = 1'b0;
            end
          end else begin
            is_pressed_next = 1'b0;
            hold_on_next    = 1'b0;
            if (hold_on) begin
              next_ramp_down_next = ~next_ramp_down;
              if (mode_ct) begin
                res.commit_ct = 1'b1;
              end else begin
                res.level_commit = 1'b1;
              end
            end else if (suppress_tap) begin
              suppress_tap_next = 1'b0;
              tap_pending_next  = 1'b0;
            end else if (!tap_pending) begin
              tap_pending_next = 1'b1;
              tap_age_next     = 16'd0;
            end else if (tap_age_next <= cfg.dtap_window) begin
              tap_pending_next = 1'b0;
              mode_ct_next     = ~mode_ct;
              res.mode_flip    = 1'b1;
            end else begin
              tap_age_next = 16'd0;
            end
          end
        end
      end else begin
        debounce_left_next = debounce_left - 16'd1;
      end
    end else if (tick.touched != stable_touched) begin
      debounce_busy_next = 1'b1;
      debounce_left_next = cfg.settle_ticks;
    end

    // Hold start.
    if (is_pressed_next && !hold_on_next && press_age_next >= cfg.hold_after) begin
      hold_on_next   = 1'b1;
      step_age_next  = 16'd0;
      ramp_down_next = next_ramp_down_next;
    end

    // Ramp step in the current mode.
    rb = ramp_step({1'b0, level_now}, {1'b0, cfg.level_step}, ramp_down_next, B_LO, B_HI);
    rc = ramp_step(temp_now, cfg.ct_step, ramp_down_next, T_LO, T_HI);
    if (hold_on_next && is_pressed_next) begin
      if (!mode_ct_next) begin
        if (step_age_next >= cfg.level_interval) begin
          step_age_next         = 16'd0;
          level_now_next        = rb.value[7:0];
          ramp_down_next        = rb.down;
          res.brightness_update = 1'b1;
        end
      end else if (step_age_next >= cfg.ct_interval) begin
        step_age_next  = 16'd0;
        temp_now_next  = rc.value;
        ramp_down_next = rc.down;
        res.ct_update  = 1'b1;
      end
    end

    // Single tap timeout.
    if (tap_pending_next && tap_age_next >= cfg.dtap_window) begin
      tap_pending_next = 1'b0;
      res.power_toggle = 1'b1;
    end

    res.hold_mode        = mode_ct_next;
    res.brightness_level = level_now_next;
    res.ct_mired         = temp_now_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_touched <= 1'b0;
      debounce_left  <= 16'd0;
      debounce_busy  <= 1'b0;
      is_pressed     <= 1'b0;
      press_age      <= 16'd0;
      hold_on        <= 1'b0;
      step_age       <= 16'd0;
      ramp_down      <= 1'b0;
      next_ramp_down <= 1'b0;
      tap_pending    <= 1'b0;
      tap_age        <= 16'd0;
      suppress_tap   <= 1'b0;
      mode_ct        <= 1'b0;
      level_now      <= tgd_pkg::LEVEL_RESET;
      temp_now       <= TEMP_RESET;
    end else if (tick_take) begin
      stable_touched <= stable_touched_next;
      debounce_left  <= debounce_left_next;
      debounce_busy  <= debounce_busy_next;
      is_pressed     <= is_pressed_next;
      press_age      <= press_age_next;
      hold_on        <= hold_on_next;
      step_age       <= step_age_next;
      ramp_down      <= ramp_down_next;
      next_ramp_down <= next_ramp_down_next;
      tap_pending    <= tap_pending_next;
      tap_age        <= tap_age_next;
      suppress_tap   <= suppress_tap_next;
      mode_ct        <= mode_ct_next;
      level_now      <= level_now_next;
      temp_now       <= temp_now_next;
    end
  end

  `TGD_ASSERT_IMPLIES(a_hold_needs_press, hold_on, is_pressed)
  `TGD_ASSERT_IMPLIES(a_idle_debounce_clear, !debounce_busy, debounce_left == 16'd0)
  `TGD_ASSERT_IMPLIES(a_commit_on_release, tick_take && (res.level_commit || res.commit_ct),
                      hold_on && !res.press_pulse)

endmodule

### rtl/tgd_outq.sv
// Result queue: two entries so the back end keeps running while a result waits.
`include "touch_gesture_dimmer_top_macros.svh"

module tgd_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tgd_pkg::result_t push_data,
  output logic             ready,
  input  logic             pop,
  output logic             empty,
  output tgd_pkg::result_t head
);

  tgd_pkg::result_t slot [2];
  logic             rd_ptr;
  logic             wr_ptr;
  logic [1:0]       count;
  logic [1:0]       count_next;
  logic             do_pop;

  assign ready  = ~count[1];
  assign empty  = (count == 2'd0);
  assign head   = slot[rd_ptr];
  assign do_pop = pop & ~empty;

  always_comb begin
    count_next = count;
    if (push && !do_pop) begin
      count_next = count + 2'd1;
    end else if (!push && do_pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  `TGD_ASSERT_IMPLIES(a_no_push_when_full, push, count != 2'd2)

endmodule

### rtl/touch_gesture_dimmer_top.sv
// Top level of the touch gesture dimmer: config registers, front end, back end, result queue.
// An accepted item is registered in the front queue; its result is registered in the result queue, then poppable.
// Throughput: one item per cycle; the back end retires one front-queue tick per cycle while the result queue has room.
// The front and result queues are two entries each, so either side may stall alone.
// Reset (synchronous, rst high): queues empty, gesture state cleared, brightness 128,
// colour temperature at the range midpoint, registers at defaults; no clearing pass.
`include "touch_gesture_dimmer_top_macros.svh"

module touch_gesture_dimmer_top #(
  parameter int BRIGHT_MIN = 0,
  parameter int BRIGHT_MAX = 255,
  parameter int TEMP_MIN   = 200,
  parameter int TEMP_MAX   = 455
) (
  input  logic                            clk,
  input  logic                            rst,
  // Tick input channel
  input  logic                            push,
  output logic                            full,
  input  tgd_pkg::sample_t                sample,
  // Result channel
  output logic                            empty,
  input  logic                            pop,
  output tgd_pkg::result_t                result,
  // Register write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tgd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tgd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tgd_pkg::cfg_t    cfg;
  tgd_pkg::tick_t   head;
  tgd_pkg::result_t core_res;
  logic             head_valid;
  logic             take;
  logic             outq_ready;

  // Registers are always writable; write them only while no item is in flight.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pin_invert     <= 1'b0;
      cfg.settle_ticks   <= tgd_pkg::RST_SETTLE_TICKS;
      cfg.hold_after     <= tgd_pkg::RST_HOLD_THRESH_MS;
      cfg.dtap_window    <= tgd_pkg::RST_DTAP_WINDOW_MS;
      cfg.level_step     <= tgd_pkg::RST_BRIGHT_STEP;
      cfg.level_interval <= tgd_pkg::RST_BRIGHT_STEP_MS;
      cfg.ct_step        <= tgd_pkg::RST_CT_STEP;
      cfg.ct_interval    <= tgd_pkg::RST_CT_STEP_MS;
    end else if (cfg_valid && cfg_ready) begin
      case (tgd_pkg::reg_idx_t'(cfg_index))
        tgd_pkg::REG_PIN_INVERT:     cfg.pin_invert     <= cfg_data[0];
        tgd_pkg::REG_SETTLE_TICKS:   cfg.settle_ticks   <= cfg_data;
        tgd_pkg::REG_HOLD_THRESH_MS: cfg.hold_after     <= cfg_data;
        tgd_pkg::REG_DTAP_WINDOW_MS: cfg.dtap_window    <= cfg_data;
        tgd_pkg::REG_BRIGHT_STEP:    cfg.level_step     <= cfg_data[7:0];
        tgd_pkg::REG_BRIGHT_STEP_MS: cfg.level_interval <= cfg_data;
        tgd_pkg::REG_CT_STEP:        cfg.ct_step        <= cfg_data[8:0];
        tgd_pkg::REG_CT_STEP_MS:     cfg.ct_interval    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: classify the pin as touched or not and queue the tick.
  tgd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pin_invert (cfg.pin_invert),
    .push       (push),
    .full       (full),
    .sample     (sample),
    .head_valid (head_valid),
    .head       (head),
    .take       (take)
  );

  // Back: advance the gesture state by one tick whenever a tick waits and the result queue has room.
  tgd_core #(
    .BRIGHT_MIN (BRIGHT_MIN),
    .BRIGHT_MAX (BRIGHT_MAX),
    .TEMP_MIN   (TEMP_MIN),
    .TEMP_MAX   (TEMP_MAX)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tick_valid (head_valid),
    .tick       (head),
    .out_ready  (outq_ready),
    .tick_take  (take),
    .res        (core_res)
  );

  // Hold finished results until the consumer pops them.
  tgd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (core_res),
    .ready     (outq_ready),
    .pop       (pop),
    .empty     (empty),
    .head      (result)
  );

endmodule
